/* hw/rtl/crpse_pkg.sv */
package crpse_pkg;

  // radio state codes
  localparam logic [1:0] PS_IDLE = 2'd0;
  localparam logic [1:0] PS_FACH = 2'd1;
  localparam logic [1:0] PS_DCH  = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_DCH_THR_DOWN = 3'd0,
    CFG_DCH_THR_UP   = 3'd1,
    CFG_DCH_TIMEOUT  = 3'd2,
    CFG_FACH_TIMEOUT = 3'd3,
    CFG_FACH_POWER   = 3'd4,
    CFG_DCH_POWER    = 3'd5,
    CFG_HEADER_BYTES = 3'd6,
    CFG_REMOTE_MODEL = 3'd7
  } cfg_reg_t;

  // serial multiplier: 12-bit power or ms-per-second factor times 32-bit milliseconds or byte count
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // serial divider: product over bandwidth or 1000
  localparam int DIV_N_W = MUL_P_W;
  localparam int DIV_D_W = 24;

  localparam int MS_PER_S = 1000;

  localparam logic [30:0] ENERGY_MAX = '1;

endpackage

/* hw/rtl/crpse_mul.sv */
// Shift-add multiplier, one bit of the short operand per cycle, MSB first.
module crpse_mul
  import crpse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  localparam int CNT_W = $clog2(MUL_A_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        a_sh    <= op_a;
        b_r     <= op_b;
        product <= '0;
      end else if (busy) begin
        product <= {product[MUL_P_W-2:0], 1'b0}
                   + (a_sh[MUL_A_W-1] ? MUL_P_W'(b_r) : '0);
        a_sh    <= {a_sh[MUL_A_W-2:0], 1'b0};
        cnt     <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/crpse_div.sv */
// Restoring divider, one quotient bit per cycle.
module crpse_div
  import crpse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den;
  logic [DIV_D_W:0]   trial_in;
  logic [DIV_D_W:0]   trial;

  always_comb begin
    trial_in = {rem, quotient[DIV_N_W-1]};
    trial    = trial_in - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // trial borrow set means the partial remainder stays
        if (trial[DIV_D_W]) begin
          rem <= trial_in[DIV_D_W-1:0];
        end else begin
          rem <= trial[DIV_D_W-1:0];
        end
        quotient <= {quotient[DIV_N_W-2:0], ~trial[DIV_D_W]};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/cellular_radio_power_state_estimator.sv */
// Counter sample and zero-bandwidth estimate: registered on accept, then S_SAMPLE or
//   S_EST, and the result is registered in S_DONE.
// Energy estimate: four or six passes through the bit-serial units, with one energy
//   part or two (multiplier then divider for the duration and for each part).
// One item at a time; the next item is taken the cycle after its result is registered,
//   even while that result waits.
// Synchronous reset clears radio state, counters and timers, and loads register defaults.
module cellular_radio_power_state_estimator
  import crpse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [31:0] now_ms,
  input  logic [31:0] rx_total,
  input  logic [31:0] tx_total,
  input  logic [23:0] payload_len,
  input  logic [23:0] link_bandwidth,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  radio_state,
  output logic [1:0]  predicted_state,
  output logic [30:0] energy_mj,
  output logic        bad_bandwidth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_WAIT, S_SAMPLE, S_EST, S_NUM, S_DUR, S_P1, S_P1M, S_P1D,
    S_P2, S_P2M, S_P2D, S_SUM, S_DONE
  } fsm_t;

  fsm_t state;

  // configuration
  logic [15:0] dch_thr_down, dch_thr_up, dch_timeout, fach_timeout;
  logic [11:0] fach_power, dch_power;
  logic [7:0]  header_bytes;
  logic        remote_model;

  // radio model state
  logic [1:0]  power_state;
  logic        have_prior;
  logic [31:0] prev_rx, prev_tx, rx_delta, tx_delta, last_activity;

  // item registers
  logic        type_r;
  logic [31:0] now_r, rx_r, tx_r;
  logic [23:0] payload_r, bw_r;
  logic [1:0]  pred_r;
  logic [15:0] since_r;
  logic [30:0] dur_r;
  logic [34:0] p1_r, p2_r;
  logic [1:0]  res_pred;
  logic [30:0] res_energy;
  logic        res_bad;

  // serial units
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_num, div_quot;
  logic [DIV_D_W-1:0] div_den;

  crpse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  crpse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_WAIT);

  // combinational helpers
  logic        rx_grow, tx_grow;
  logic [31:0] dr, dt, idle_ms, since_raw;
  logic [24:0] len_c;
  logic [15:0] data_thr, ack_thr, since_to;
  logic        pred_dch, two_parts;
  logic [11:0] p1_mw, p2_mw;
  logic [31:0] p1_ms, p2_ms;
  logic [35:0] sum_c;

  always_comb begin
    rx_grow  = rx_r > prev_rx;
    tx_grow  = tx_r > prev_tx;
    dr       = rx_grow ? rx_r - prev_rx : '0;
    dt       = tx_grow ? tx_r - prev_tx : '0;
    idle_ms  = now_r - last_activity;

    len_c    = 25'(payload_r) + 25'(header_bytes);
    data_thr = remote_model ? dch_thr_down : dch_thr_up;
    ack_thr  = remote_model ? dch_thr_up : dch_thr_down;
    pred_dch = (power_state == PS_DCH)
               || (33'(rx_delta) + 33'(len_c) >= 33'(data_thr))
               || (33'(tx_delta) + 33'(header_bytes) >= 33'(ack_thr));
    since_raw = now_r - last_activity;
    since_to  = (power_state == PS_FACH) ? fach_timeout : dch_timeout;

    two_parts = (pred_r == PS_DCH) && (power_state != PS_DCH);
    p2_mw     = fach_power;
    p2_ms     = 32'(since_r);
    if (power_state == PS_IDLE && pred_r == PS_DCH) begin
      p1_mw = fach_power;
      p1_ms = 32'(fach_timeout);
      p2_mw = dch_power;
      p2_ms = {1'b0, dur_r} + 32'(dch_timeout);
    end else if (power_state == PS_IDLE) begin
      p1_mw = fach_power;
      p1_ms = {1'b0, dur_r} + 32'(fach_timeout);
    end else if (power_state == PS_FACH && pred_r == PS_DCH) begin
      p1_mw = dch_power;
      p1_ms = {1'b0, dur_r} + 32'(dch_timeout);
    end else if (power_state == PS_FACH) begin
      p1_mw = fach_power;
      p1_ms = {1'b0, dur_r} + 32'(since_r);
    end else begin
      p1_mw = dch_power;
      p1_ms = {1'b0, dur_r} + 32'(since_r);
    end

    sum_c = 36'(p1_r) + 36'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_WAIT;
      res_valid     <= 1'b0;
      mul_start     <= 1'b0;
      div_start     <= 1'b0;
      dch_thr_down  <= 16'd119;
      dch_thr_up    <= 16'd151;
      dch_timeout   <= 16'd4000;
      fach_timeout  <= 16'd6000;
      fach_power    <= 12'd401;
      dch_power     <= 12'd570;
      header_bytes  <= 8'd52;
      remote_model  <= 1'b1;
      power_state   <= PS_IDLE;
      have_prior    <= 1'b0;
      prev_rx       <= '0;
      prev_tx       <= '0;
      rx_delta      <= '0;
      tx_delta      <= '0;
      last_activity <= '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DCH_THR_DOWN: dch_thr_down <= cfg_data;
          CFG_DCH_THR_UP:   dch_thr_up   <= cfg_data;
          CFG_DCH_TIMEOUT:  dch_timeout  <= cfg_data;
          CFG_FACH_TIMEOUT: fach_timeout <= cfg_data;
          CFG_FACH_POWER:   fach_power   <= cfg_data[11:0];
          CFG_DCH_POWER:    dch_power    <= cfg_data[11:0];
          CFG_HEADER_BYTES: header_bytes <= cfg_data[7:0];
          CFG_REMOTE_MODEL: remote_model <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_WAIT: begin
          if (req_valid) begin
            type_r    <= req_type;
            now_r     <= now_ms;
            rx_r      <= rx_total;
            tx_r      <= tx_total;
            payload_r <= payload_len;
            bw_r      <= link_bandwidth;
            state     <= req_type ? S_EST : S_SAMPLE;
          end
        end

        S_SAMPLE: begin
          res_pred   <= PS_IDLE;
          res_energy <= '0;
          res_bad    <= 1'b0;
          if (!have_prior) begin
            // first sample only primes the counters
            have_prior <= 1'b1;
            rx_delta   <= '0;
            tx_delta   <= '0;
            prev_rx    <= rx_r;
            prev_tx    <= tx_r;
          end else if (rx_grow || tx_grow) begin
            last_activity <= now_r;
            if (dr >= 32'(dch_thr_down) || dt >= 32'(dch_thr_up)) begin
              power_state <= PS_DCH;
            end else if (power_state == PS_IDLE) begin
              power_state <= PS_FACH;
            end
            rx_delta <= dr;
            tx_delta <= dt;
            prev_rx  <= rx_r;
            prev_tx  <= tx_r;
          end else if (power_state == PS_DCH) begin
            if (idle_ms >= 32'(dch_timeout)) begin
              power_state   <= PS_FACH;
              last_activity <= now_r;
            end
          end else if (power_state == PS_FACH) begin
            if (idle_ms >= 32'(fach_timeout)) begin
              power_state <= PS_IDLE;
            end
          end
          state <= S_DONE;
        end

        S_EST: begin
          pred_r   <= pred_dch ? PS_DCH : PS_FACH;
          res_pred <= pred_dch ? PS_DCH : PS_FACH;
          since_r  <= (since_raw > 32'(since_to)) ? since_to : since_raw[15:0];
          if (bw_r == '0) begin
            res_bad    <= 1'b1;
            res_energy <= ENERGY_MAX;
            state      <= S_DONE;
          end else begin
            res_bad   <= 1'b0;
            mul_a     <= MUL_A_W'(MS_PER_S);
            mul_b     <= MUL_B_W'(len_c);
            mul_start <= 1'b1;
            state     <= S_NUM;
          end
        end

        S_NUM: begin
          if (mul_done) begin
            div_num   <= mul_prod;
            div_den   <= bw_r;
            div_start <= 1'b1;
            state     <= S_DUR;
          end
        end

        S_DUR: begin
          if (div_done) begin
            dur_r <= (|div_quot[DIV_N_W-1:31]) ? ENERGY_MAX : div_quot[30:0];
            state <= S_P1;
          end
        end

        S_P1: begin
          mul_a     <= p1_mw;
          mul_b     <= p1_ms;
          mul_start <= 1'b1;
          state     <= S_P1M;
        end

        S_P1M: begin
          if (mul_done) begin
            div_num   <= mul_prod;
            div_den   <= DIV_D_W'(MS_PER_S);
            div_start <= 1'b1;
            state     <= S_P1D;
          end
        end

        S_P1D: begin
          if (div_done) begin
            p1_r <= div_quot[34:0];
            p2_r <= '0;
            state <= two_parts ? S_P2 : S_SUM;
          end
        end

        S_P2: begin
          mul_a     <= p2_mw;
          mul_b     <= p2_ms;
          mul_start <= 1'b1;
          state     <= S_P2M;
        end

        S_P2M: begin
          if (mul_done) begin
            div_num   <= mul_prod;
            div_den   <= DIV_D_W'(MS_PER_S);
            div_start <= 1'b1;
            state     <= S_P2D;
          end
        end

        S_P2D: begin
          if (div_done) begin
            p2_r  <= div_quot[34:0];
            state <= S_SUM;
          end
        end

        S_SUM: begin
          res_energy <= (sum_c > 36'(ENERGY_MAX)) ? ENERGY_MAX : sum_c[30:0];
          state      <= S_DONE;
        end

        S_DONE: begin
          // hold until the output register is free
          if (!res_valid || !res_stall) begin
            res_valid       <= 1'b1;
            radio_state     <= power_state;
            predicted_state <= type_r ? res_pred : PS_IDLE;
            energy_mj       <= res_energy;
            bad_bandwidth   <= res_bad;
            state           <= S_WAIT;
          end
        end

        default: state <= S_WAIT;
      endcase
    end
  end

endmodule

/* bench/tb_cellular_radio_power_state_estimator.sv */
`timescale 1ns / 100ps

module tb_cellular_radio_power_state_estimator;
  import crpse_pkg::*;

  localparam longint unsigned SAT31 = 64'h7FFF_FFFF;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 256;

  typedef struct packed {
    logic [1:0]  state;
    logic [1:0]  pred;
    logic [30:0] energy;
    logic        bad;
  } radio_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        req_type = 1'b0;
  logic [31:0] now_ms = '0;
  logic [31:0] rx_total = '0;
  logic [31:0] tx_total = '0;
  logic [23:0] payload_len = '0;
  logic [23:0] link_bandwidth = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  radio_state;
  logic [1:0]  predicted_state;
  logic [30:0] energy_mj;
  logic        bad_bandwidth;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cellular_radio_power_state_estimator u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .now_ms(now_ms), .rx_total(rx_total), .tx_total(tx_total),
    .payload_len(payload_len), .link_bandwidth(link_bandwidth),
    .res_valid(res_valid), .res_stall(res_stall), .radio_state(radio_state),
    .predicted_state(predicted_state), .energy_mj(energy_mj),
    .bad_bandwidth(bad_bandwidth),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow registers, reset values
  logic [15:0] reg_thr_down = 16'd119;
  logic [15:0] reg_thr_up   = 16'd151;
  logic [15:0] reg_dch_to   = 16'd4000;
  logic [15:0] reg_fach_to  = 16'd6000;
  logic [11:0] reg_fach_mw  = 12'd401;
  logic [11:0] reg_dch_mw   = 12'd570;
  logic [7:0]  reg_hdr      = 8'd52;
  logic        reg_remote   = 1'b1;

  // radio model state
  logic [1:0]  model_state    = PS_IDLE;
  logic        model_primed   = 1'b0;
  logic [31:0] model_rx       = '0;
  logic [31:0] model_tx       = '0;
  logic [31:0] model_rx_delta = '0;
  logic [31:0] model_tx_delta = '0;
  logic [31:0] model_last_act = '0;

  radio_report_t predicted_reports[$];

  int unsigned err_cnt = 0;
  int unsigned sample_cnt = 0;
  int unsigned estimate_cnt = 0;
  int unsigned cfg_writes = 0;
  int unsigned report_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          gap_on = 1'b1;
  bit          stall_on = 1'b1;

  logic [31:0] stim_now = '0;
  logic [31:0] stim_rx = '0;
  logic [31:0] stim_tx = '0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [23:0] rand24();
    logic [31:0] r;
    r = $urandom;
    return r[23:0];
  endfunction

  function automatic longint unsigned mj_of(longint unsigned mw, longint unsigned ms);
    return (mw * ms) / 64'd1000;
  endfunction

  // result side stall: random bursts, mostly short
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin : report_check
    radio_report_t want;
    if (!rst && res_valid && !res_stall) begin
      if (predicted_reports.size() == 0) begin
        $error("result with no item outstanding: state %0d pred %0d energy %0d bad %0d",
               radio_state, predicted_state, energy_mj, bad_bandwidth);
        err_cnt++;
      end else begin
        want = predicted_reports.pop_front();
        report_cnt++;
        if (radio_state !== want.state) begin
          $error("radio_state: expected %0d, got %0d", want.state, radio_state);
          err_cnt++;
        end
        if (predicted_state !== want.pred) begin
          $error("predicted_state: expected %0d, got %0d", want.pred, predicted_state);
          err_cnt++;
        end
        if (energy_mj !== want.energy) begin
          $error("energy_mj: expected %0d, got %0d", want.energy, energy_mj);
          err_cnt++;
        end
        if (bad_bandwidth !== want.bad) begin
          $error("bad_bandwidth: expected %0d, got %0d", want.bad, bad_bandwidth);
          err_cnt++;
        end
      end
    end
  end

  // updates the radio model with one accepted item and queues its report
  task automatic advance_radio_model(input logic kind, input logic [31:0] t, rx, tx,
                                     input logic [23:0] len_in, bw_in);
    radio_report_t rep;
    logic [31:0] grow_rx, grow_tx, quiet_ms;
    logic [1:0] nxt;
    longint unsigned total_len, data_thr, ack_thr, ack_q, dur, since, mj;
    longint unsigned fach_mw, dch_mw, fach_to, dch_to;
    rep = '0;
    fach_mw = 64'(reg_fach_mw);
    dch_mw = 64'(reg_dch_mw);
    fach_to = 64'(reg_fach_to);
    dch_to = 64'(reg_dch_to);
    if (kind == 1'b0) begin
      if (!model_primed) begin
        model_primed = 1'b1;
        model_rx_delta = '0;
        model_tx_delta = '0;
        model_rx = rx;
        model_tx = tx;
      end else if (rx > model_rx || tx > model_tx) begin
        grow_rx = (rx > model_rx) ? rx - model_rx : 32'd0;
        grow_tx = (tx > model_tx) ? tx - model_tx : 32'd0;
        model_last_act = t;
        if (grow_rx >= 32'(reg_thr_down) || grow_tx >= 32'(reg_thr_up)) model_state = PS_DCH;
        else if (model_state == PS_IDLE) model_state = PS_FACH;
        model_rx_delta = grow_rx;
        model_tx_delta = grow_tx;
        model_rx = rx;
        model_tx = tx;
      end else begin
        quiet_ms = t - model_last_act;
        if (model_state == PS_DCH) begin
          if (quiet_ms >= 32'(reg_dch_to)) begin
            model_state = PS_FACH;
            model_last_act = t;
          end
        end else if (model_state == PS_FACH) begin
          if (quiet_ms >= 32'(reg_fach_to)) model_state = PS_IDLE;
        end
      end
    end else begin
      total_len = 64'(len_in) + 64'(reg_hdr);
      data_thr = 64'(reg_remote ? reg_thr_down : reg_thr_up);
      ack_thr = 64'(reg_remote ? reg_thr_up : reg_thr_down);
      ack_q = 64'(model_tx_delta) + 64'(reg_hdr);
      nxt = PS_FACH;
      if (model_state == PS_DCH || total_len + 64'(model_rx_delta) >= data_thr) nxt = PS_DCH;
      if (ack_q >= ack_thr) nxt = PS_DCH;
      rep.pred = nxt;
      if (bw_in == 24'd0) begin
        rep.bad = 1'b1;
        rep.energy = ENERGY_MAX;
      end else begin
        dur = (total_len * 64'd1000) / 64'(bw_in);
        if (dur > SAT31) dur = SAT31;
        quiet_ms = t - model_last_act;
        since = 64'(quiet_ms);
        case (model_state)
          PS_IDLE: begin
            if (nxt == PS_DCH)
              mj = mj_of(fach_mw, fach_to) + mj_of(dch_mw, dur + dch_to);
            else
              mj = mj_of(fach_mw, dur + fach_to);
          end
          PS_FACH: begin
            if (since > fach_to) since = fach_to;
            if (nxt == PS_DCH)
              mj = mj_of(dch_mw, dur + dch_to) + mj_of(fach_mw, since);
            else
              mj = mj_of(fach_mw, dur + since);
          end
          default: begin
            if (since > dch_to) since = dch_to;
            mj = mj_of(dch_mw, dur + since);
          end
        endcase
        rep.energy = (mj > SAT31) ? ENERGY_MAX : mj[30:0];
      end
    end
    rep.state = model_state;
    predicted_reports.push_back(rep);
  endtask

  // valid is left high on return; the next call lowers it only if it idles
  task automatic send_item(input logic kind, input logic [31:0] t, rx, tx,
                           input logic [23:0] len_in, bw_in);
    int unsigned gap;
    gap = gap_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    now_ms <= t;
    rx_total <= rx;
    tx_total <= tx;
    payload_len <= len_in;
    link_bandwidth <= bw_in;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_radio_model(kind, t, rx, tx, len_in, bw_in);
    if (kind) estimate_cnt++;
    else sample_cnt++;
  endtask

  task automatic wait_results_done();
    req_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DCH_THR_DOWN: reg_thr_down = val;
      CFG_DCH_THR_UP:   reg_thr_up = val;
      CFG_DCH_TIMEOUT:  reg_dch_to = val;
      CFG_FACH_TIMEOUT: reg_fach_to = val;
      CFG_FACH_POWER:   reg_fach_mw = val[11:0];
      CFG_DCH_POWER:    reg_dch_mw = val[11:0];
      CFG_HEADER_BYTES: reg_hdr = val[7:0];
      CFG_REMOTE_MODEL: reg_remote = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic load_config(input logic [15:0] thr_dn, thr_up, dch_to, fach_to,
                             fach_mw, dch_mw, hdr, remote);
    wait_results_done();
    set_reg(CFG_DCH_THR_DOWN, thr_dn);
    set_reg(CFG_DCH_THR_UP, thr_up);
    set_reg(CFG_DCH_TIMEOUT, dch_to);
    set_reg(CFG_FACH_TIMEOUT, fach_to);
    set_reg(CFG_FACH_POWER, fach_mw);
    set_reg(CFG_DCH_POWER, dch_mw);
    set_reg(CFG_HEADER_BYTES, hdr);
    set_reg(CFG_REMOTE_MODEL, remote);
    cfg_valid <= 1'b0;
  endtask

  // time steps cluster around the timers so both drops are hit from each side
  function automatic logic [31:0] pick_step();
    int unsigned r;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 200);
    if (r < 50) begin
      base = 32'(reg_dch_to);
      return base + $urandom_range(0, 4) - 2;
    end
    if (r < 70) begin
      base = 32'(reg_fach_to);
      return base + $urandom_range(0, 4) - 2;
    end
    if (r < 95) return $urandom_range(0, 20000);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_inc(input logic [15:0] thr);
    int unsigned r;
    logic [31:0] t32;
    t32 = 32'(thr);
    r = $urandom_range(0, 99);
    if (r < 30) return 32'd0;
    if (r < 50) return $urandom_range(1, 64);
    if (r < 60) return (t32 == 0) ? 32'd0 : t32 - 1;
    if (r < 75) return t32;
    if (r < 80) return t32 + 1;
    return $urandom_range(0, 1 << 20);
  endfunction

  function automatic logic [23:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 24'($urandom_range(0, 300));
    if (r < 80) return 24'($urandom_range(0, 65535));
    if (r < 90) return 24'hFF_FFFF;
    return rand24();
  endfunction

  function automatic logic [23:0] pick_bw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 24'd0;
    if (r < 30) return 24'($urandom_range(1, 1000));
    if (r < 45) return 24'hFF_FFFF;
    return rand24();
  endfunction

  // mostly plausible counter streams; a few jumps put the counters anywhere
  task automatic run_traffic(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      stim_now = stim_now + pick_step();
      if (r < 35) begin
        send_item(1'b1, stim_now, $urandom, $urandom, pick_len(), pick_bw());
      end else if (r < 92) begin
        if ($urandom_range(0, 2) != 0) begin
          stim_rx = stim_rx + pick_inc(reg_thr_down);
          stim_tx = stim_tx + pick_inc(reg_thr_up);
        end
        send_item(1'b0, stim_now, stim_rx, stim_tx, rand24(), rand24());
      end else begin
        stim_now = $urandom;
        stim_rx = $urandom;
        stim_tx = $urandom;
        send_item(1'b0, stim_now, stim_rx, stim_tx, rand24(), rand24());
      end
    end
  endtask

  // reset register values; start just below the time wrap
  task automatic test_directed_cases();
    logic [31:0] t0, act;
    t0 = 32'hFFFF_F000;
    send_item(1'b1, t0, $urandom, $urandom, 24'd0, 24'd1000);  // estimate before any sample
    send_item(1'b0, t0, 32'd1000, 32'd2000, rand24(), rand24());  // priming only
    act = t0 + 100;
    send_item(1'b0, act, 32'd1010, 32'd2000, rand24(), rand24());  // small growth, to FACH
    send_item(1'b1, act + 100, $urandom, $urandom, 24'd40, 24'hFF_FFFF);
    send_item(1'b1, act + 200, $urandom, $urandom, 24'd57, 24'd500);  // hits data threshold
    send_item(1'b1, act + 200, $urandom, $urandom, 24'd0, 24'd0);  // zero bandwidth
    send_item(1'b0, act + 5999, 32'd1010, 32'd2000, rand24(), rand24());  // across the wrap
    send_item(1'b0, act + 6000, 32'd1010, 32'd2000, rand24(), rand24());  // FACH timeout
    send_item(1'b1, act + 6100, $urandom, $urandom, 24'hFF_FFFF, 24'd1);  // duration saturates
    act = act + 7000;
    send_item(1'b0, act, 32'd5, 32'd2151, rand24(), rand24());  // rx drops, tx at threshold
    send_item(1'b1, act + 10000, $urandom, $urandom, 24'd1000, 24'd2000);
    send_item(1'b0, act + 3999, 32'd5, 32'd2151, rand24(), rand24());
    act = act + 4000;
    send_item(1'b0, act, 32'd5, 32'd2151, rand24(), rand24());  // DCH timeout
    send_item(1'b0, act + 4000, 32'd5, 32'd2151, rand24(), rand24());
    send_item(1'b1, act + 50000, $urandom, $urandom, 24'd300, 24'd3);
    act = act + 60000;
    send_item(1'b0, act, 32'd123, 32'd2151, rand24(), rand24());  // one below threshold
    act = act + 10;
    send_item(1'b0, act, 32'd242, 32'd2151, rand24(), rand24());  // exactly threshold
    act = act + 10;
    send_item(1'b0, act, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rand24(), rand24());
    send_item(1'b0, act + 1, 32'd0, 32'd0, rand24(), rand24());
    send_item(1'b1, act + 2, $urandom, $urandom, 24'hFF_FFFF, 24'hFF_FFFF);
    stim_now = act + 2;
    stim_rx = 32'd0;
    stim_tx = 32'd0;
  endtask

  task automatic test_default_traffic();
    run_traffic(250);
  endtask

  task automatic test_zero_config();
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(120);
  endtask

  task automatic test_max_config();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFE);
    run_traffic(150);
  endtask

  task automatic test_random_configs();
    repeat (3) begin
      load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_traffic(120);
    end
  endtask

  task automatic test_back_to_back();
    load_config(16'd119, 16'd151, 16'd4000, 16'd6000, 16'd401, 16'd570, 16'd52, 16'd1);
    gap_on = 1'b0;
    stall_on = 1'b0;
    run_traffic(120);
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_default_traffic();
    test_zero_config();
    test_max_config();
    test_random_configs();
    test_back_to_back();
    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d counter samples and %0d energy estimates across %0d register writes",
             sample_cnt, estimate_cnt, cfg_writes);
    $display("Compared %0d results, %0d field mismatches", report_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/crpse_pkg.sv
hw/rtl/crpse_mul.sv
hw/rtl/crpse_div.sv
hw/rtl/cellular_radio_power_state_estimator.sv
bench/tb_cellular_radio_power_state_estimator.sv
